@@ rtl/vmop_pkg.sv @@
// vmop_pkg: types and constants of the vm operand read/write unit
// used by every rtl file of the block; depends on nothing

package vmop_pkg;

   localparam logic [1:0] KIND_MEMORY    = 2'd0;
   localparam logic [1:0] KIND_IMMEDIATE = 2'd1;
   localparam logic [1:0] KIND_REGISTER  = 2'd2;

   localparam logic [1:0] PART_WORD   = 2'd0;
   localparam logic [1:0] PART_LOW    = 2'd1;
   localparam logic [1:0] PART_SECOND = 2'd2;
   localparam logic [1:0] PART_HALF   = 2'd3;

   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   localparam int BASE_REGS = 4;

   localparam logic [2:0] CSR_SEG0_BASE = 3'd0;
   localparam logic [2:0] CSR_SEG0_SIZE = 3'd4;

   typedef struct packed {
      logic               action;
      logic [1:0]         operand_kind;
      logic [3:0]         register_index;
      logic [1:0]         part_select;
      logic signed [15:0] displacement;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               segment_fault;
      logic               immediate_write;
   } rsp_type;

   // item passed from front to back, register operand already read
   typedef struct packed {
      req_type     req;
      logic [31:0] reg_value;
      logic        reg_valid;
   } work_type;

endpackage

@@ rtl/vmop_front.sv @@
// vmop_front: accepts requests, reads the register file, queues work
// depends on vmop_pkg

module vmop_front #(
   parameter int REGISTERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  vmop_pkg::req_type  req_data,
   input  logic [31:0]        regs [REGISTERS],
   input  logic               busy,
   output logic               wq_valid,
   input  logic               wq_ready,
   output vmop_pkg::work_type wq_data
);

   localparam int RW = $clog2(REGISTERS);

   logic               valid_ff, valid_in;
   vmop_pkg::work_type data_ff;

   // one request in flight between front and back at a time
   assign req_ready = !valid_ff && !busy;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !wq_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff.req       <= req_data;
         data_ff.reg_valid <= 32'(req_data.register_index) < REGISTERS;
         data_ff.reg_value <= (32'(req_data.register_index) < REGISTERS) ?
                              regs[RW'(req_data.register_index)] : 32'd0;
      end
   end

   assign wq_valid = valid_ff;
   assign wq_data  = data_ff;

endmodule

@@ rtl/vmop_back.sv @@
// vmop_back: carries out one operand access on memory, registers or an immediate
// depends on vmop_pkg

module vmop_back #(
   parameter int MEM_BYTES = 16384,
   parameter int SEGMENTS  = 4,
   parameter int REGISTERS = 16,
   parameter int IP_INDEX  = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wq_valid,
   output logic               wq_ready,
   input  vmop_pkg::work_type wq_data,
   input  logic [13:0]        seg_base [vmop_pkg::BASE_REGS],
   input  logic               size_load,
   input  logic [1:0]         size_index,
   input  logic [14:0]        size_value,
   output logic [31:0]        regs [REGISTERS],
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vmop_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam int RW = $clog2(REGISTERS);
   localparam int SW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MEM  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [31:0] regs_ff [REGISTERS];
   logic [14:0] size_ff [SEGMENTS];
   logic [7:0]  mem [MEM_BYTES];
   logic [1:0]  byte_ff;
   logic [2:0]  width_ff;
   logic [AW-1:0] addr_ff;
   logic [31:0] acc_ff;
   logic        write_ff;
   logic [31:0] wval_ff;
   logic [7:0]  rd_ff;
   logic        rd_pend_ff;
   logic        rd_last_ff;
   vmop_pkg::rsp_type out_ff;

   vmop_pkg::req_type q;
   logic [3:0]  seg;
   logic signed [17:0] off;
   logic [2:0]  width;
   logic        seg_ok;
   logic [17:0] addr;
   logic [17:0] endp;
   logic        ok;
   logic [31:0] r;

   assign q     = wq_data.req;
   assign r     = wq_data.reg_value;
   assign seg   = r[19:16];
   assign off   = $signed({2'b00, r[15:0]}) + 18'(q.displacement);
   assign width = (q.part_select == vmop_pkg::PART_WORD) ? 3'd4 :
                  (q.part_select == vmop_pkg::PART_SECOND) ? 3'd2 : 3'd1;
   assign seg_ok = (32'(seg) < SEGMENTS) && (32'(seg) < vmop_pkg::BASE_REGS);
   assign addr  = 18'(seg_base[seg[1:0]]) + 18'(off);
   assign endp  = 18'(off) + 18'(width);
   assign ok    = !off[17] && seg_ok && (32'(addr) + 32'(width) <= MEM_BYTES);

   assign wq_ready = (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE) || wq_valid;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = out_ff;
   assign regs      = regs_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (wq_valid) begin
               state_in = (q.operand_kind == vmop_pkg::KIND_MEMORY && ok) ?
                          ST_MEM : ST_OUT;
            end
         end
         ST_MEM: begin
            if (write_ff ? byte_ff == 2'(width_ff - 3'd1) : rd_last_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // memory port: one byte a cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_MEM && write_ff) begin
         mem[addr_ff + AW'(byte_ff)] <= wval_ff[8*(int'(width_ff)-1-int'(byte_ff)) +: 8];
      end
      rd_ff <= mem[addr_ff + AW'(byte_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         rd_last_ff <= 1'b0;
         for (int i = 0; i < REGISTERS; i++) regs_ff[i] <= 32'd0;
         for (int i = 0; i < SEGMENTS; i++) size_ff[i] <= 15'd0;
      end else begin
         if (size_load && 32'(size_index) < SEGMENTS) begin
            size_ff[SW'(size_index)] <= size_value;
         end
         if (state_ff == ST_IDLE && wq_valid) begin
            byte_ff    <= 2'd0;
            rd_pend_ff <= 1'b0;
            rd_last_ff <= 1'b0;
            width_ff   <= width;
            addr_ff    <= addr[AW-1:0];
            acc_ff     <= 32'd0;
            write_ff   <= q.action;
            wval_ff    <= q.write_value;
            out_ff     <= '0;
            case (q.operand_kind)
               vmop_pkg::KIND_MEMORY: begin
                  if (!ok) begin
                     out_ff.segment_fault <= 1'b1;
                     if (q.action == vmop_pkg::ACTION_WRITE && IP_INDEX < REGISTERS) begin
                        regs_ff[IP_INDEX] <= 32'(size_ff[0]);
                     end
                  end else if (q.action == vmop_pkg::ACTION_WRITE) begin
                     if (32'(size_ff[SW'(seg)]) < 32'(endp)) begin
                        size_ff[SW'(seg)] <= endp[14:0];
                     end
                  end
               end
               vmop_pkg::KIND_REGISTER: begin
                  if (q.action == vmop_pkg::ACTION_READ) begin
                     case (q.part_select)
                        vmop_pkg::PART_WORD:   out_ff.read_value <= r;
                        vmop_pkg::PART_LOW:    out_ff.read_value <= {{24{r[7]}}, r[7:0]};
                        vmop_pkg::PART_SECOND: out_ff.read_value <= {{24{r[15]}}, r[15:8]};
                        default:               out_ff.read_value <= {{16{r[15]}}, r[15:0]};
                     endcase
                  end else if (wq_data.reg_valid) begin
                     case (q.part_select)
                        vmop_pkg::PART_WORD:   regs_ff[RW'(q.register_index)] <= q.write_value;
                        vmop_pkg::PART_LOW:    regs_ff[RW'(q.register_index)] <=
                                                  {r[31:8], q.write_value[7:0]};
                        vmop_pkg::PART_SECOND: regs_ff[RW'(q.register_index)] <=
                                                  {r[31:16], q.write_value[7:0], r[7:0]};
                        default:               regs_ff[RW'(q.register_index)] <=
                                                  {r[31:16], q.write_value[15:0]};
                     endcase
                  end
               end
               default: begin
                  if (q.action == vmop_pkg::ACTION_READ) begin
                     out_ff.read_value <= 32'(q.displacement);
                  end else begin
                     out_ff.immediate_write <= 1'b1;
                  end
               end
            endcase
         end else if (state_ff == ST_MEM) begin
            if (write_ff) begin
               byte_ff <= byte_ff + 2'd1;
            end else begin
               rd_pend_ff <= 1'b1;
               rd_last_ff <= (byte_ff == 2'(width_ff - 3'd1));
               if (rd_pend_ff) begin
                  acc_ff <= {acc_ff[23:0], rd_ff};
               end
               if (byte_ff != 2'(width_ff - 3'd1)) begin
                  byte_ff <= byte_ff + 2'd1;
               end
               if (rd_last_ff) begin
                  case (width_ff)
                     3'd4:    out_ff.read_value <= {acc_ff[23:0], rd_ff};
                     3'd2:    out_ff.read_value <= {{16{acc_ff[7]}}, acc_ff[7:0], rd_ff};
                     default: out_ff.read_value <= {{24{rd_ff[7]}}, rd_ff};
                  endcase
               end
            end
         end
      end
   end

endmodule

@@ rtl/vm_operand_read_write_unit.sv @@
// vm_operand_read_write_unit: top level of the vm operand unit
// depends on vmop_pkg, vmop_front, vmop_back
//
//  channel | handshake           | payload
//  req     | req_valid/req_ready | vmop_pkg::req_type
//  rsp     | rsp_valid/rsp_ready | vmop_pkg::rsp_type
//  csr     | csr_valid/csr_ready | csr_index, csr_data
//
// memory operands move one byte a cycle on the single memory port.
// reset clears registers and segment sizes at once. requests stall
// while one is in flight or the response waits.

module vm_operand_read_write_unit #(
   parameter int MEM_BYTES = 16384,
   parameter int SEGMENTS  = 4,
   parameter int REGISTERS = 16,
   parameter int IP_INDEX  = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vmop_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vmop_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [14:0]       csr_data
);

   logic [13:0]        base_ff [vmop_pkg::BASE_REGS];
   logic [31:0]        regs [REGISTERS];
   logic               busy, wq_valid, wq_ready, size_load;
   vmop_pkg::work_type wq_data;

   assign csr_ready = 1'b1;
   assign size_load = csr_valid && csr_index >= vmop_pkg::CSR_SEG0_SIZE;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vmop_pkg::BASE_REGS; i++) base_ff[i] <= 14'd0;
      end else if (csr_valid && csr_index < vmop_pkg::CSR_SEG0_SIZE) begin
         base_ff[csr_index[1:0] - vmop_pkg::CSR_SEG0_BASE[1:0]] <= csr_data[13:0];
      end
   end

   vmop_front #(.REGISTERS(REGISTERS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data, .regs, .busy,
      .wq_valid, .wq_ready, .wq_data
   );

   vmop_back #(.MEM_BYTES(MEM_BYTES), .SEGMENTS(SEGMENTS), .REGISTERS(REGISTERS),
               .IP_INDEX(IP_INDEX)) u_back (
      .clock, .reset, .wq_valid, .wq_ready, .wq_data, .seg_base(base_ff),
      .size_load, .size_index(csr_index[1:0]), .size_value(csr_data), .regs, .busy,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response waits");
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.segment_fault && rsp_data.immediate_write))
      else $error("fault and immediate write together");
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second request accepted");

endmodule
